### src/reno_congestion_window_unit_defines.svh
// assertion macros for the congestion window unit
`ifndef RENO_CONGESTION_WINDOW_UNIT_DEFINES_SVH
`define RENO_CONGESTION_WINDOW_UNIT_DEFINES_SVH

// consequent must hold in the cycle after the antecedent
`define RCW_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

// condition must hold at every edge outside reset
`define RCW_ASSERT_ALWAYS(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond)) else $error(msg);

`endif

### src/rcw_pkg.sv
// ----------------------------------------------------------------------------
// rcw_pkg
// shared types and constants of the congestion window unit
// ----------------------------------------------------------------------------
`default_nettype none
package rcw_pkg;
  localparam int unsigned DUP_ACK_LIMIT_DEF = 3;
  localparam logic [15:0] SEG_RESET = 16'd1024;
  localparam logic [31:0] THR_RESET = 32'd64000;
  localparam logic [23:0] RTT_RESET = 24'd100000;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RTT = 2'd2;

  typedef enum logic [1:0] {
    PH_SS = 2'd0,
    PH_CA = 2'd1,
    PH_FR = 2'd2
  } phase_t;

  // request as queued by the front part
  typedef struct packed {
    logic        is_timeout;
    logic [31:0] ack;
    logic        rtt_valid;
    logic [23:0] sample;
  } req_t;

  // result request
  typedef struct packed {
    logic [31:0] window;
    logic [31:0] threshold;
    logic [31:0] limit;
    logic [1:0]  phase;
    logic        retransmit;
    logic [26:0] timeout;
    logic        restart;
  } res_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [32:0] b);
    logic [33:0] s;
    s = {2'b00, a} + {1'b0, b};
    return (s[33:32] != 2'b00) ? 32'hFFFF_FFFF : s[31:0];
  endfunction
endpackage
`default_nettype wire

### src/reno_congestion_window_unit.sv
// ----------------------------------------------------------------------------
// reno_congestion_window_unit
// congestion window controller with round trip estimator
// ----------------------------------------------------------------------------
//  channel  | handshake      | payload
//  input    | push / full    | opcode, ack_number, rtt_valid, rtt_sample
//  result   | empty / pop    | window, threshold, limit, phase, flags, timeout
//  config   | cfg_we         | cfg_index, cfg_data
// an ack or timeout passes the states S_RTT and S_OUT; a new ack in avoidance
// also waits in S_DIV for the bit-serial divider that computes the window increment
// synchronous reset restores registers and state; a two-entry queue
// decouples the input, a result register holds one result until popped
`default_nettype none
`include "reno_congestion_window_unit_defines.svh"
module reno_congestion_window_unit #(
  parameter int unsigned DUP_ACK_LIMIT = rcw_pkg::DUP_ACK_LIMIT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic                           in_opcode,
  input  wire logic [31:0]                    in_ack_number,
  input  wire logic                           in_rtt_valid,
  input  wire logic [23:0]                    in_rtt_sample,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output logic [31:0]                         out_window_bytes,
  output logic [31:0]                         out_threshold_bytes,
  output logic [31:0]                         out_send_limit,
  output logic [1:0]                          out_phase,
  output logic                                out_retransmit,
  output logic [26:0]                         out_timeout_ticks,
  output logic                                out_timer_restart,
  input  wire logic                           cfg_we,
  input  wire logic [rcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                    cfg_data
);
  import rcw_pkg::*;

  logic [15:0] seg_r;
  logic [31:0] thr_r;
  logic [23:0] rtt_r;
  logic        q_valid, q_take, res_valid, res_take;
  req_t        q_req, in_req;
  res_t        res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= SEG_RESET; thr_r <= THR_RESET; rtt_r <= RTT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEG: seg_r <= cfg_data[15:0];
        CFG_THR: thr_r <= cfg_data;
        CFG_RTT: rtt_r <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  assign in_req = '{is_timeout: in_opcode, ack: in_ack_number,
                    rtt_valid: in_rtt_valid, sample: in_rtt_sample};

  rcw_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_req(in_req),
    .q_valid(q_valid), .q_take(q_take), .q_req(q_req)
  );

  rcw_back #(.DUP_ACK_LIMIT(DUP_ACK_LIMIT)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take), .q_req(q_req),
    .seg(seg_r), .init_thr(thr_r), .init_rtt(rtt_r), .rst_state(1'b0),
    .res_valid(res_valid), .res_take(res_take), .res(res)
  );

  // result port
  assign out_empty           = !res_valid;
  assign res_take            = out_pop && res_valid;
  assign out_window_bytes    = res.window;
  assign out_threshold_bytes = res.threshold;
  assign out_send_limit      = res.limit;
  assign out_phase           = res.phase;
  assign out_retransmit      = res.retransmit;
  assign out_timeout_ticks   = res.timeout;
  assign out_timer_restart   = res.restart;

  // checks
  `RCW_ASSERT_ALWAYS(a_phase_ok, clk, rst_n, out_empty || out_phase != 2'd3, "bad phase")
  `RCW_ASSERT_NEXT(a_pop_clears, clk, rst_n, res_take, out_empty, "result not cleared")
  `RCW_ASSERT_NEXT(a_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_window_bytes), "result lost")
endmodule
`default_nettype wire

### src/rcw_front.sv
// ----------------------------------------------------------------------------
// rcw_front
// accepts requests into a two-entry queue for the back part
// ----------------------------------------------------------------------------
`default_nettype none
module rcw_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire rcw_pkg::req_t in_req,
  output logic               q_valid,
  input  wire logic          q_take,
  output rcw_pkg::req_t      q_req
);
  import rcw_pkg::*;

  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push_ok;

  assign in_full = (cnt_r == 2'd2);
  assign push_ok = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_req   = mem_r[rp_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push_ok) mem_r[wp_r] <= in_req;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) wp_r <= ~wp_r;
      if (q_take) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, q_take};
    end
  end
endmodule
`default_nettype wire

### src/rcw_divider.sv
// ----------------------------------------------------------------------------
// rcw_divider
// radix-2 restoring divider, 32-bit quotient of a 32-bit dividend
// ----------------------------------------------------------------------------
`default_nettype none
module rcw_divider (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  logic [31:0] q_r, d_r;
  logic [32:0] rem_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] shifted;
  logic [33:0] diff;

  assign shifted  = {rem_r[31:0], q_r[31]};
  assign diff     = {1'b0, shifted} - {2'b00, d_r};
  assign done     = done_r;
  assign quotient = q_r;

  // one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      if (!diff[33]) begin
        rem_r <= diff[32:0];
        q_r   <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= shifted;
        q_r   <= {q_r[30:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

### src/rcw_back.sv
// ----------------------------------------------------------------------------
// rcw_back
// window, threshold and round trip state; executes one request at a time
// ----------------------------------------------------------------------------
`default_nettype none
module rcw_back #(
  parameter int unsigned DUP_ACK_LIMIT = rcw_pkg::DUP_ACK_LIMIT_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  output logic               q_take,
  input  wire rcw_pkg::req_t q_req,
  input  wire logic [15:0]   seg,
  input  wire logic [31:0]   init_thr,
  input  wire logic [23:0]   init_rtt,
  input  wire logic          rst_state,
  output logic               res_valid,
  input  wire logic          res_take,
  output rcw_pkg::res_t      res
);
  import rcw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RTT  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t      st_r;
  req_t        req_r;
  logic [31:0] win_r, thr_r, hi_r, lat_r, lim_r;
  phase_t      ph_r;
  logic [2:0]  dup_r;
  logic [23:0] est_r, dev_r;
  logic [26:0] to_r;
  logic        rsnd_r, rst_r, res_valid_r;
  logic        div_start, div_done;
  logic [31:0] div_q, seg_sq;
  logic [24:0] est_sum;
  logic [23:0] est_new, diff_abs;
  logic [26:0] dev_sum;
  logic [2:0]  dup_inc;
  logic [31:0] half_win;
  logic [33:0] dup_seg;
  logic [15:0] rs_seg;
  logic [31:0] rs_thr;
  logic [23:0] rs_rtt;

  // start values: reset constants under reset, configured values on a soft restart
  assign rs_seg = rst_n ? seg : SEG_RESET;
  assign rs_thr = rst_n ? init_thr : THR_RESET;
  assign rs_rtt = rst_n ? init_rtt : RTT_RESET;

  assign seg_sq    = {16'd0, seg} * {16'd0, seg};
  assign est_sum   = {1'b0, est_r} + {1'b0, req_r.sample};
  assign est_new   = est_sum[24:1];
  assign diff_abs  = (est_new >= req_r.sample) ? est_new - req_r.sample
                                                : req_r.sample - est_new;
  assign dev_sum   = {3'b000, dev_r} + {2'b00, dev_r, 1'b0} + {3'b000, diff_abs};
  assign dup_inc   = (dup_r == 3'd7) ? dup_r : dup_r + 3'd1;
  assign half_win  = {1'b0, win_r[31:1]};
  assign dup_seg   = 34'(DUP_ACK_LIMIT) * {18'd0, seg};
  assign q_take    = (st_r == S_IDLE) && q_valid && !res_valid_r;
  assign div_start = (st_r == S_RTT) && !req_r.is_timeout && (req_r.ack > hi_r)
                     && (ph_r != PH_SS) && (ph_r != PH_FR) && (win_r != 32'd0);
  assign res_valid = res_valid_r;

  rcw_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(seg_sq), .divisor(win_r), .done(div_done), .quotient(div_q)
  );

  // result fields, taken from the state registers
  assign res = '{window: win_r, threshold: thr_r, limit: lim_r, phase: ph_r,
                 retransmit: rsnd_r, timeout: to_r, restart: rst_r};

  // sequencer and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n || rst_state) begin
      st_r <= S_IDLE; res_valid_r <= 1'b0;
      win_r <= {16'd0, rs_seg}; thr_r <= rs_thr; ph_r <= PH_SS; dup_r <= '0;
      hi_r <= '0; lat_r <= '0; lim_r <= {16'd0, rs_seg};
      est_r <= rs_rtt; dev_r <= '0; to_r <= {3'b000, rs_rtt};
      rsnd_r <= 1'b0; rst_r <= 1'b0;
    end else begin
      if (res_take) res_valid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_take) begin
            req_r <= q_req;
            st_r  <= S_RTT;
          end
        end
        S_RTT: begin
          rsnd_r <= 1'b0; rst_r <= 1'b0;
          st_r   <= S_OUT;
          if (req_r.is_timeout) begin
            dup_r <= '0; thr_r <= half_win; win_r <= {16'd0, seg};
            lim_r <= sat_add(lat_r, {17'd0, seg});
            ph_r <= PH_SS; rsnd_r <= 1'b1; rst_r <= 1'b1;
          end else begin
            lat_r <= req_r.ack;
            if (req_r.rtt_valid) begin
              est_r <= est_new;
              dev_r <= dev_sum[25:2];
              to_r  <= {3'b000, est_new} + {1'b0, dev_sum[25:2], 2'b00};
            end
            if (req_r.ack > hi_r) begin
              hi_r <= req_r.ack; rst_r <= 1'b1; dup_r <= '0;
              case (ph_r)
                PH_SS: begin
                  win_r <= sat_add(win_r, {17'd0, seg});
                  lim_r <= sat_add(req_r.ack, {1'b0, sat_add(win_r, {17'd0, seg})});
                  if (sat_add(win_r, {17'd0, seg}) >= thr_r) ph_r <= PH_CA;
                end
                PH_FR: begin
                  win_r <= thr_r; ph_r <= PH_CA;
                  lim_r <= sat_add(req_r.ack, {1'b0, thr_r});
                end
                default: begin
                  ph_r <= PH_CA;
                  if (win_r != 32'd0) st_r <= S_DIV;
                  else begin
                    win_r <= {16'd0, seg};
                    lim_r <= sat_add(req_r.ack, {17'd0, seg});
                  end
                end
              endcase
            end else if (req_r.ack == hi_r) begin
              dup_r <= dup_inc;
              if ((32'(dup_inc) == 32'(DUP_ACK_LIMIT)) && (ph_r != PH_FR)) begin
                ph_r <= PH_FR; thr_r <= half_win; rsnd_r <= 1'b1;
                win_r <= sat_add(half_win, dup_seg[32:0] | {dup_seg[33], 32'd0});
                lim_r <= sat_add(req_r.ack, {1'b0,
                         sat_add(half_win, dup_seg[32:0] | {dup_seg[33], 32'd0})});
              end else if (ph_r == PH_FR) begin
                win_r <= sat_add(win_r, {17'd0, seg});
                lim_r <= sat_add(req_r.ack, {1'b0, sat_add(win_r, {17'd0, seg})});
              end
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            win_r <= sat_add(win_r, {1'b0, div_q});
            lim_r <= sat_add(lat_r, {1'b0, sat_add(win_r, {1'b0, div_q})});
            st_r  <= S_OUT;
          end
        end
        S_OUT: begin
          res_valid_r <= 1'b1;
          st_r        <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
